### rtl/core/dpcs_pkg.sv
// shared types, constants and helpers for the dual pwm crossfade sequencer
package dpcs_pkg;

  // field widths
  localparam int unsigned DUTY_W = 10;
  localparam int unsigned TICK_W = 14;
  localparam int unsigned MS_W   = 16;

  // pwm timing, in timer ticks
  localparam logic [TICK_W-1:0] PERIOD_TICKS = 14'd10000;
  localparam logic [TICK_W-1:0] MIN_TICKS    = 14'd50;
  localparam logic [TICK_W-1:0] ON_CAP_TICKS = 14'd9950;
  localparam logic [TICK_W-1:0] RESET_TICKS  = 14'd200;

  // duty scale and fade turning points
  localparam logic [DUTY_W-1:0] DUTY_FULL = 10'd1000;
  localparam logic [DUTY_W-1:0] FADE_LOW  = 10'd1;
  localparam logic [DUTY_W-1:0] FADE_HIGH = 10'd999;

  typedef enum logic [1:0] {
    FADE_A_DOWN = 2'd0,
    FADE_B_UP   = 2'd1,
    FADE_B_DOWN = 2'd2,
    FADE_A_UP   = 2'd3
  } fade_stage_e;

  typedef enum logic [1:0] {
    PWM_A_ON  = 2'd0,
    PWM_A_OFF = 2'd1,
    PWM_B_ON  = 2'd2,
    PWM_B_OFF = 2'd3
  } pwm_phase_e;

  typedef enum logic [1:0] {
    REG_START_DUTY_A = 2'd0,
    REG_START_DUTY_B = 2'd1,
    REG_FADE_PERIOD  = 2'd2
  } cfg_reg_e;

  // register write strobes and values handed to the fade sequencer
  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic              wr_period;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [MS_W-1:0]   period;
  } cfg_wr_t;

  // duty levels and fade stage
  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    fade_stage_e       stage;
  } fade_state_t;

  // limit a register value to full duty
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] d);
    return (d > DUTY_FULL) ? DUTY_FULL : d;
  endfunction

endpackage

### rtl/core/dual_pwm_crossfade_sequencer_top.sv
// top level: apb registers, pwm phase countdown and result handshake
//
// Two-channel pwm with a crossfade sequencer. Every input beat is one timer
// tick carrying ms_strobe_i; every tick gives exactly one result beat with
// both pin levels, both current duty levels and the fade stage after the tick.
// The tick countdown, pwm phase, pin levels and duty levels are the result
// register itself: a beat accepted at one edge shows on out_valid_o from the
// next cycle on, and throughput is 1 beat per cycle while out_stall_i holds no result.
// The whole tick update (fade step, then countdown reload from the fresh
// duty) is one level of logic between the state registers.
// in_stall_o is high only while a result waits and out_stall_i holds it;
// a result taken in the same cycle frees room for the next beat.
// Reset clears all state: countdown 200, phase A on, pins low, duties 0,
// fade stage 0 and all registers 0; no result is pending after reset.
// Registers sit at byte addresses 0 (start_duty_a), 4 (start_duty_b) and 8 (fade_period_ms)
// and are to be written only while no beat is in flight; the block does not enforce this.
module dual_pwm_crossfade_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        ms_strobe_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        pin_a_o,
  output logic        pin_b_o,
  output logic [9:0]  level_a_o,
  output logic [9:0]  level_b_o,
  output logic [1:0]  fade_phase_o
);

  logic [dpcs_pkg::DUTY_W-1:0] start_a_q, start_b_q;
  logic [dpcs_pkg::MS_W-1:0]   period_q;
  logic                        apb_wr;
  dpcs_pkg::cfg_reg_e          reg_idx;
  dpcs_pkg::cfg_wr_t           cfg_wr;
  dpcs_pkg::fade_state_t       fade_q, fade_d;

  logic [dpcs_pkg::TICK_W-1:0] count_q, count_d;
  dpcs_pkg::pwm_phase_e        phase_q, phase_d;
  logic                        out_a_q, out_a_d, out_b_q, out_b_d;
  logic [dpcs_pkg::TICK_W-1:0] raw_on, on_t, off_t;
  logic [dpcs_pkg::DUTY_W-1:0] reload_duty;
  logic                        out_valid_q, accept;

  // register port
  assign pready  = 1'b1;
  assign apb_wr  = psel && penable && pwrite;
  assign reg_idx = dpcs_pkg::cfg_reg_e'(paddr[3:2]);

  always_comb begin
    cfg_wr = '{wr_a: 1'b0, wr_b: 1'b0, wr_period: 1'b0,
               duty_a: dpcs_pkg::clamp_duty(pwdata[dpcs_pkg::DUTY_W-1:0]),
               duty_b: dpcs_pkg::clamp_duty(pwdata[dpcs_pkg::DUTY_W-1:0]),
               period: period_q};
    prdata = '0;
    unique case (reg_idx)
      dpcs_pkg::REG_START_DUTY_A: begin
        cfg_wr.wr_a = apb_wr;
        prdata      = {22'd0, start_a_q};
      end
      dpcs_pkg::REG_START_DUTY_B: begin
        cfg_wr.wr_b = apb_wr;
        prdata      = {22'd0, start_b_q};
      end
      dpcs_pkg::REG_FADE_PERIOD: begin
        cfg_wr.wr_period = apb_wr;
        prdata           = {16'd0, period_q};
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_a_q <= '0;
      start_b_q <= '0;
      period_q  <= '0;
    end else begin
      if (cfg_wr.wr_a)      start_a_q <= pwdata[dpcs_pkg::DUTY_W-1:0];
      if (cfg_wr.wr_b)      start_b_q <= pwdata[dpcs_pkg::DUTY_W-1:0];
      if (cfg_wr.wr_period) period_q  <= pwdata[dpcs_pkg::MS_W-1:0];
    end
  end

  // handshake: the state registers double as the result register
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept || (out_valid_q && out_stall_i);
    end
  end

  // fade sequencer
  dpcs_fade_seq u_fade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .ms_strobe_i (ms_strobe_i),
    .cfg_i       (cfg_wr),
    .state_o     (fade_q),
    .next_o      (fade_d)
  );

  // on and off times from the freshly faded duty of the channel entered next
  always_comb begin
    phase_d     = dpcs_pkg::pwm_phase_e'(phase_q + 1'b1);
    reload_duty = phase_d[1] ? fade_d.duty_b : fade_d.duty_a;
    raw_on      = ({4'd0, reload_duty} << 3) + ({4'd0, reload_duty} << 1);
    on_t        = (raw_on > dpcs_pkg::ON_CAP_TICKS) ? dpcs_pkg::ON_CAP_TICKS : raw_on;
    off_t       = (raw_on > dpcs_pkg::ON_CAP_TICKS) ? dpcs_pkg::MIN_TICKS
                                                    : dpcs_pkg::PERIOD_TICKS - raw_on;
  end

  // countdown and phase advance
  always_comb begin
    count_d = count_q - 1'b1;
    out_a_d = out_a_q;
    out_b_d = out_b_q;
    if (count_q <= 14'd1) begin
      unique case (phase_d)
        dpcs_pkg::PWM_A_ON: begin
          out_a_d = (on_t != '0);
          count_d = (on_t != '0) ? on_t : dpcs_pkg::MIN_TICKS;
        end
        dpcs_pkg::PWM_A_OFF: begin
          out_a_d = 1'b0;
          count_d = off_t;
        end
        dpcs_pkg::PWM_B_ON: begin
          out_b_d = (on_t != '0);
          count_d = (on_t != '0) ? on_t : dpcs_pkg::MIN_TICKS;
        end
        dpcs_pkg::PWM_B_OFF: begin
          out_b_d = 1'b0;
          count_d = off_t;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= dpcs_pkg::RESET_TICKS;
      phase_q <= dpcs_pkg::PWM_A_ON;
      out_a_q <= 1'b0;
      out_b_q <= 1'b0;
    end else if (accept) begin
      count_q <= count_d;
      out_a_q <= out_a_d;
      out_b_q <= out_b_d;
      if (count_q <= 14'd1) phase_q <= phase_d;
    end
  end

  // result fields
  assign out_valid_o  = out_valid_q;
  assign pin_a_o      = out_a_q;
  assign pin_b_o      = out_b_q;
  assign level_a_o    = fade_q.duty_a;
  assign level_b_o    = fade_q.duty_b;
  assign fade_phase_o = fade_q.stage;

endmodule

### rtl/core/dpcs_fade_seq.sv
// millisecond counter and four-stage crossfade sequencer for both duty levels
module dpcs_fade_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 ms_strobe_i,
  input  dpcs_pkg::cfg_wr_t    cfg_i,
  output dpcs_pkg::fade_state_t state_o,
  output dpcs_pkg::fade_state_t next_o
);

  logic [dpcs_pkg::MS_W-1:0]   ms_cnt_q, ms_cnt_d, ms_inc;
  logic [dpcs_pkg::DUTY_W-1:0] duty_a_q, duty_a_d;
  logic [dpcs_pkg::DUTY_W-1:0] duty_b_q, duty_b_d;
  dpcs_pkg::fade_stage_e       stage_q, stage_d;
  logic                        fade_now;

  // ms counting and one fade step per period, none while the period is zero
  always_comb begin
    ms_inc   = ms_cnt_q + 1'b1;
    ms_cnt_d = ms_cnt_q;
    duty_a_d = duty_a_q;
    duty_b_d = duty_b_q;
    stage_d  = stage_q;
    fade_now = 1'b0;
    if (ms_strobe_i && (cfg_i.period != '0)) begin
      if (ms_inc >= cfg_i.period) begin
        ms_cnt_d = '0;
        fade_now = 1'b1;
      end else begin
        ms_cnt_d = ms_inc;
      end
    end
    if (fade_now) begin
      unique case (stage_q)
        dpcs_pkg::FADE_A_DOWN: begin
          if (duty_a_q != '0) duty_a_d = duty_a_q - 1'b1;
          if (duty_a_d <= dpcs_pkg::FADE_LOW) stage_d = dpcs_pkg::FADE_B_UP;
        end
        dpcs_pkg::FADE_B_UP: begin
          if (duty_b_q < dpcs_pkg::DUTY_FULL) duty_b_d = duty_b_q + 1'b1;
          if (duty_b_d >= dpcs_pkg::FADE_HIGH) stage_d = dpcs_pkg::FADE_B_DOWN;
        end
        dpcs_pkg::FADE_B_DOWN: begin
          if (duty_b_q != '0) duty_b_d = duty_b_q - 1'b1;
          if (duty_b_d <= dpcs_pkg::FADE_LOW) stage_d = dpcs_pkg::FADE_A_UP;
        end
        dpcs_pkg::FADE_A_UP: begin
          if (duty_a_q < dpcs_pkg::DUTY_FULL) duty_a_d = duty_a_q + 1'b1;
          if (duty_a_d >= dpcs_pkg::FADE_HIGH) stage_d = dpcs_pkg::FADE_A_DOWN;
        end
      endcase
    end
  end

  // state registers, register writes take priority
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_cnt_q <= '0;
      duty_a_q <= '0;
      duty_b_q <= '0;
      stage_q  <= dpcs_pkg::FADE_A_DOWN;
    end else if (cfg_i.wr_a) begin
      duty_a_q <= cfg_i.duty_a;
      stage_q  <= dpcs_pkg::FADE_A_DOWN;
    end else if (cfg_i.wr_b) begin
      duty_b_q <= cfg_i.duty_b;
      stage_q  <= dpcs_pkg::FADE_A_DOWN;
    end else if (cfg_i.wr_period) begin
      ms_cnt_q <= '0;
    end else if (step_i) begin
      ms_cnt_q <= ms_cnt_d;
      duty_a_q <= duty_a_d;
      duty_b_q <= duty_b_d;
      stage_q  <= stage_d;
    end
  end

  assign state_o = '{duty_a: duty_a_q, duty_b: duty_b_q, stage: stage_q};
  assign next_o  = '{duty_a: duty_a_d, duty_b: duty_b_d, stage: stage_d};

endmodule

### rtl/core/dpcs_checker.sv
// port-level checks for the dual pwm crossfade sequencer, bound to the top level
module dpcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        pin_a_o,
  input logic        pin_b_o,
  input logic [9:0]  level_a_o,
  input logic [9:0]  level_b_o
);

  // a held result beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // every accepted tick shows a result in the next cycle
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted tick gave no result");

  // the input is only held off by a stalled pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // the two channels never drive high together
  a_pins_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pin_a_o && pin_b_o))
    else $error("both channels high");

  // duty levels stay within full scale
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_a_o <= 10'd1000) && (level_b_o <= 10'd1000))
    else $error("duty level above full scale");

endmodule

bind dual_pwm_crossfade_sequencer_top dpcs_checker u_dpcs_checker (.*);

### verif/dual_pwm_crossfade_sequencer_top_tb.sv
// self-checking testbench: timer tick beats, apb register setup and per-tick level checks
`timescale 1ns / 100ps

module dual_pwm_crossfade_sequencer_top_tb;

  localparam int unsigned RANDOM_TICKS = 960;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned LONG_HOLD_AT = 300;

  localparam logic [3:0] ADDR_DUTY_A = {dpcs_pkg::REG_START_DUTY_A, 2'b00};
  localparam logic [3:0] ADDR_DUTY_B = {dpcs_pkg::REG_START_DUTY_B, 2'b00};
  localparam logic [3:0] ADDR_FADE   = {dpcs_pkg::REG_FADE_PERIOD, 2'b00};
  localparam logic [3:0] ADDR_UNUSED = 4'hC;

  // one result beat as seen on the output side
  typedef struct packed {
    logic                        pin_a;
    logic                        pin_b;
    logic [dpcs_pkg::DUTY_W-1:0] level_a;
    logic [dpcs_pkg::DUTY_W-1:0] level_b;
    logic [1:0]                  stage;
  } pin_levels_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        ms_strobe_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        pin_a_o;
  logic        pin_b_o;
  logic [9:0]  level_a_o;
  logic [9:0]  level_b_o;
  logic [1:0]  fade_phase_o;

  // pending ticks and the levels they should produce
  logic        tick_q[$];
  pin_levels_t levels_q[$];
  int unsigned err_cnt = 0;

  // register mirror
  logic [dpcs_pkg::DUTY_W-1:0] reg_duty_a;
  logic [dpcs_pkg::DUTY_W-1:0] reg_duty_b;
  logic [dpcs_pkg::MS_W-1:0]   reg_fade_ms;

  // predicted block state
  int unsigned                 countdown;
  dpcs_pkg::pwm_phase_e        pwm_ph;
  logic                        exp_pin_a;
  logic                        exp_pin_b;
  logic [dpcs_pkg::DUTY_W-1:0] lvl_a;
  logic [dpcs_pkg::DUTY_W-1:0] lvl_b;
  dpcs_pkg::fade_stage_e       fade_st;
  logic [dpcs_pkg::MS_W-1:0]   ms_cnt;

  // sender and receiver pacing
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;
  int          roll_in;
  int          roll_out;
  bit          steady_in = 1'b0;
  bit          steady_out = 1'b0;
  bit          held_long = 1'b0;

  dual_pwm_crossfade_sequencer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ms_strobe_i (ms_strobe_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pin_a_o     (pin_a_o),
    .pin_b_o     (pin_b_o),
    .level_a_o   (level_a_o),
    .level_b_o   (level_b_o),
    .fade_phase_o(fade_phase_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_error(input string msg);
    if (err_cnt < 10) $display("mismatch: %0s", msg);
    err_cnt++;
  endtask

  // pin high time for a duty, capped so the low part keeps its minimum
  function automatic int on_span(input logic [dpcs_pkg::DUTY_W-1:0] d);
    int t;
    t = int'(d) * int'(dpcs_pkg::PERIOD_TICKS) / int'(dpcs_pkg::DUTY_FULL);
    if (t + int'(dpcs_pkg::MIN_TICKS) > int'(dpcs_pkg::PERIOD_TICKS))
      t = int'(dpcs_pkg::ON_CAP_TICKS);
    return t;
  endfunction

  // pin low time for a duty, never below the minimum
  function automatic int off_span(input logic [dpcs_pkg::DUTY_W-1:0] d);
    int hi;
    int t;
    hi = int'(d) * int'(dpcs_pkg::PERIOD_TICKS) / int'(dpcs_pkg::DUTY_FULL);
    t = (hi >= int'(dpcs_pkg::PERIOD_TICKS)) ? 0 : int'(dpcs_pkg::PERIOD_TICKS) - hi;
    if (t < int'(dpcs_pkg::MIN_TICKS)) t = int'(dpcs_pkg::MIN_TICKS);
    return t;
  endfunction

  // advance the predicted state by one timer tick and queue the expected beat
  task automatic tick_model(input logic strobe);
    int span;
    // fade sequencer runs first so an expiry sees the new duty
    if (strobe && reg_fade_ms != '0) begin
      ms_cnt = ms_cnt + 16'd1;
      if (ms_cnt >= reg_fade_ms) begin
        ms_cnt = '0;
        case (fade_st)
          dpcs_pkg::FADE_A_DOWN: begin
            if (lvl_a != '0) lvl_a = lvl_a - 10'd1;
            if (lvl_a <= dpcs_pkg::FADE_LOW) fade_st = dpcs_pkg::FADE_B_UP;
          end
          dpcs_pkg::FADE_B_UP: begin
            if (lvl_b < dpcs_pkg::DUTY_FULL) lvl_b = lvl_b + 10'd1;
            if (lvl_b >= dpcs_pkg::FADE_HIGH) fade_st = dpcs_pkg::FADE_B_DOWN;
          end
          dpcs_pkg::FADE_B_DOWN: begin
            if (lvl_b != '0) lvl_b = lvl_b - 10'd1;
            if (lvl_b <= dpcs_pkg::FADE_LOW) fade_st = dpcs_pkg::FADE_A_UP;
          end
          default: begin
            if (lvl_a < dpcs_pkg::DUTY_FULL) lvl_a = lvl_a + 10'd1;
            if (lvl_a >= dpcs_pkg::FADE_HIGH) fade_st = dpcs_pkg::FADE_A_DOWN;
          end
        endcase
      end
    end
    // pwm countdown, phase advance and reload on expiry
    if (countdown <= 1) begin
      pwm_ph = dpcs_pkg::pwm_phase_e'(pwm_ph + 2'd1);
      case (pwm_ph)
        dpcs_pkg::PWM_A_ON: begin
          span = on_span(lvl_a);
          exp_pin_a = (span != 0);
          if (span == 0) span = int'(dpcs_pkg::MIN_TICKS);
        end
        dpcs_pkg::PWM_A_OFF: begin
          exp_pin_a = 1'b0;
          span = off_span(lvl_a);
        end
        dpcs_pkg::PWM_B_ON: begin
          span = on_span(lvl_b);
          exp_pin_b = (span != 0);
          if (span == 0) span = int'(dpcs_pkg::MIN_TICKS);
        end
        default: begin
          exp_pin_b = 1'b0;
          span = off_span(lvl_b);
        end
      endcase
      countdown = span;
    end else begin
      countdown--;
    end
    levels_q.push_back('{exp_pin_a, exp_pin_b, lvl_a, lvl_b, fade_st});
  endtask

  // apb write: setup then access, mirrored into the predictor afterwards
  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (dpcs_pkg::cfg_reg_e'(addr[3:2]))
      dpcs_pkg::REG_START_DUTY_A: begin
        reg_duty_a = data[dpcs_pkg::DUTY_W-1:0];
        lvl_a = (reg_duty_a > dpcs_pkg::DUTY_FULL) ? dpcs_pkg::DUTY_FULL : reg_duty_a;
        fade_st = dpcs_pkg::FADE_A_DOWN;
      end
      dpcs_pkg::REG_START_DUTY_B: begin
        reg_duty_b = data[dpcs_pkg::DUTY_W-1:0];
        lvl_b = (reg_duty_b > dpcs_pkg::DUTY_FULL) ? dpcs_pkg::DUTY_FULL : reg_duty_b;
        fade_st = dpcs_pkg::FADE_A_DOWN;
      end
      dpcs_pkg::REG_FADE_PERIOD: begin
        reg_fade_ms = data[dpcs_pkg::MS_W-1:0];
        ms_cnt = '0;
      end
      default: ;
    endcase
  endtask

  task automatic apb_read_check(input logic [3:0] addr, input logic [31:0] want);
    logic [31:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      flag_error($sformatf("register at %0d exp %0h got %0h", addr, want, got));
  endtask

  task automatic check_registers();
    apb_read_check(ADDR_DUTY_A, {22'd0, reg_duty_a});
    apb_read_check(ADDR_DUTY_B, {22'd0, reg_duty_b});
    apb_read_check(ADDR_FADE, {16'd0, reg_fade_ms});
  endtask

  // sender holds off until every beat is through, then lets the pipe settle
  task automatic wait_idle();
    while (tick_q.size() != 0 || in_valid_i || levels_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_duty();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1:    v = 32'd0;
      2:       v = $urandom_range(1000, 1023);
      3, 4:    v = $urandom_range(0, 3);
      5:       v = $urandom_range(996, 1000);
      default: v = $urandom_range(0, 1023);
    endcase
    // junk above the field width must be dropped
    if ($urandom_range(0, 3) == 0) v = v | ($urandom() & 32'hFFFF_FC00);
    return v;
  endfunction

  // sender: one tick beat per handshake, random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) tick_model(ms_strobe_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0 || tick_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i  <= 1'b1;
          ms_strobe_i <= tick_q.pop_front();
          if ($urandom_range(0, 149) == 0) steady_in = !steady_in;
          roll_in = $urandom_range(0, 99);
          if (steady_in || roll_in < 50) gap_left = 0;
          else if (roll_in < 85) gap_left = $urandom_range(1, 3);
          else if (roll_in < 97) gap_left = $urandom_range(4, 10);
          else gap_left = $urandom_range(20, 40);
        end
      end
    end
  end

  // receiver: check each beat against the oldest prediction, random stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (levels_q.size() == 0) begin
          flag_error($sformatf("unexpected beat a=%0b b=%0b la=%0d lb=%0d st=%0d",
                               pin_a_o, pin_b_o, level_a_o, level_b_o, fade_phase_o));
        end else begin
          pin_levels_t want;
          want = levels_q.pop_front();
          if (pin_a_o !== want.pin_a || pin_b_o !== want.pin_b ||
              level_a_o !== want.level_a || level_b_o !== want.level_b ||
              fade_phase_o !== want.stage)
            flag_error($sformatf(
              {"beat %0d exp a=%0b b=%0b la=%0d lb=%0d st=%0d",
               " got a=%0b b=%0b la=%0d lb=%0d st=%0d"},
              results_seen, want.pin_a, want.pin_b, want.level_a, want.level_b, want.stage,
              pin_a_o, pin_b_o, level_a_o, level_b_o, fade_phase_o));
        end
      end
      if ($urandom_range(0, 299) == 0) steady_out = !steady_out;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (results_seen >= LONG_HOLD_AT && !held_long) begin
        // one long back-pressure stretch so the input side has to stall
        held_long = 1'b1;
        hold_left = 79;
        out_stall_i <= 1'b1;
      end else if (steady_out) begin
        out_stall_i <= 1'b0;
      end else begin
        roll_out = $urandom_range(0, 99);
        if (roll_out < 65) begin
          out_stall_i <= 1'b0;
        end else begin
          if (roll_out < 90) hold_left = $urandom_range(0, 2);
          else if (roll_out < 98) hold_left = $urandom_range(5, 20);
          else hold_left = $urandom_range(30, 70);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  // watchdog: give up when no beat moves for too long
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("tb: failure");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned odds;
    logic [31:0] period;

    reg_duty_a  = '0;
    reg_duty_b  = '0;
    reg_fade_ms = '0;
    countdown   = int'(dpcs_pkg::RESET_TICKS);
    pwm_ph      = dpcs_pkg::PWM_A_ON;
    exp_pin_a   = 1'b0;
    exp_pin_b   = 1'b0;
    lvl_a       = '0;
    lvl_b       = '0;
    fade_st     = dpcs_pkg::FADE_A_DOWN;
    ms_cnt      = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // defaults after reset, fading off so strobes change nothing
    check_registers();
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b1);
    wait_idle();

    // duties next to both turning points, upper data bits set, unmapped write
    apb_write(ADDR_DUTY_A, 32'hFFFF_FC02);
    apb_write(ADDR_DUTY_B, 32'h0000_03E6);
    apb_write(ADDR_FADE, 32'hFFFF_0001);
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    check_registers();
    repeat (5) tick_q.push_back(1'b1);
    wait_idle();

    // fade steps saturating at zero and at full duty
    apb_write(ADDR_DUTY_A, 32'd0);
    apb_write(ADDR_DUTY_B, 32'd1000);
    apb_write(ADDR_FADE, 32'd1);
    repeat (3) tick_q.push_back(1'b1);
    wait_idle();

    // duty above full is clamped, fade every second strobe
    apb_write(ADDR_DUTY_A, 32'd1023);
    apb_write(ADDR_DUTY_B, 32'd1);
    apb_write(ADDR_FADE, 32'd2);
    check_registers();
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b1);
    wait_idle();

    // longest fade period
    apb_write(ADDR_FADE, 32'd65535);
    check_registers();
    repeat (4) tick_q.push_back(1'b1);
    wait_idle();

    // random phases: new settings, then a run of ticks at some strobe density
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      if ($urandom_range(0, 9) < 7) apb_write(ADDR_DUTY_A, pick_duty());
      if ($urandom_range(0, 9) < 7) apb_write(ADDR_DUTY_B, pick_duty());
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 9))
          0, 1:    period = 32'd0;
          2:       period = 32'd65535;
          3:       period = $urandom_range(4, 40);
          default: period = $urandom_range(1, 3);
        endcase
        if ($urandom_range(0, 3) == 0) period = period | ($urandom() & 32'hFFFF_0000);
        apb_write(ADDR_FADE, period);
      end
      if ($urandom_range(0, 19) == 0) apb_write(ADDR_UNUSED, $urandom());
      check_registers();
      len  = $urandom_range(40, 160);
      odds = $urandom_range(1, 8);
      repeat (len) tick_q.push_back($urandom_range(1, odds) == 1);
      sent += len;
      wait_idle();
    end

    if (levels_q.size() != 0)
      flag_error($sformatf("%0d expected beats never arrived", levels_q.size()));
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/dpcs_pkg.sv
rtl/core/dpcs_fade_seq.sv
rtl/core/dual_pwm_crossfade_sequencer_top.sv
rtl/core/dpcs_checker.sv
verif/dual_pwm_crossfade_sequencer_top_tb.sv
